// File: src/ctlb_pkg.sv
// ----------------------------------------------------------------------------
// ctlb_pkg
// Shared constants, command and status types for the census line buffer.
// ----------------------------------------------------------------------------
package ctlb_pkg;

   localparam int WIN_H        = 7;
   localparam int WIN_W        = 7;
   localparam int MAX_WIDTH    = 4096;

   localparam int HALF_H       = WIN_H / 2;
   localparam int HALF_W       = WIN_W / 2;

   localparam int PIX_BITS     = 8;
   localparam int CFG_BITS     = 13;
   localparam int WORD_BITS    = 48;
   localparam int WORD_IDX     = $clog2(WORD_BITS);
   localparam int COL_OUT_BITS = 12;
   localparam int COL_BITS     = $clog2(MAX_WIDTH);
   localparam int SLOT_BITS    = $clog2(WIN_H);
   localparam int TAP_BITS     = $clog2(WIN_W);

   localparam int RESET_WIDTH  = 3840;

   typedef logic [PIX_BITS-1:0]  pixel_type;
   typedef logic [COL_BITS-1:0]  col_type;
   typedef logic [SLOT_BITS-1:0] slot_type;

   // Commands from the controller to the datapath
   typedef struct packed {
      logic clear_en;   // write zero to one row of every line slot
      logic take;       // accept a pixel beat
      logic read_en;    // fetch one window column from all slots
      logic load_out;   // load a census word into the output register
   } cmd_type;

   // Status from the datapath to the controller
   typedef struct packed {
      logic clear_last;       // final row of the clearing pass
      logic take_has_result;  // pixel on the input causes at least one word
      logic read_last;        // rightmost window column being fetched
      logic out_free;         // output register can take a word
      logic at_end;           // current centre column is the final one
   } status_type;

   // Line slot that feeds window row 'row' (row 0 is the oldest line)
   function automatic slot_type slot_of_row(slot_type newest, slot_type row);
      logic [SLOT_BITS:0] sum;
      sum = {1'b0, newest} + {1'b0, row} + (SLOT_BITS+1)'(1);
      if (sum >= (SLOT_BITS+1)'(WIN_H)) begin
         sum = sum - (SLOT_BITS+1)'(WIN_H);
      end
      return sum[SLOT_BITS-1:0];
   endfunction

endpackage

// File: src/ctlb_ram.sv
// ----------------------------------------------------------------------------
// ctlb_ram
// Generic simple dual-port RAM: one write port, one registered read port.
// ----------------------------------------------------------------------------
module ctlb_ram #(
   parameter int WIDTH = 8,
   parameter int DEPTH = 4096
) (
   input  logic                     clock,
   input  logic                     wr_en,
   input  logic [$clog2(DEPTH)-1:0] wr_addr,
   input  logic [WIDTH-1:0]         wr_data,
   input  logic                     rd_en,
   input  logic [$clog2(DEPTH)-1:0] rd_addr,
   output logic [WIDTH-1:0]         rd_data
);

   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
      if (rd_en) begin
         rd_data_ff <= mem_ff[rd_addr];
      end
   end

   assign rd_data = rd_data_ff;

endmodule

// File: src/ctlb_ctrl.sv
// ----------------------------------------------------------------------------
// ctlb_ctrl
// Sequencer: clearing pass, pixel intake, window fetch and word emission.
// ----------------------------------------------------------------------------
module ctlb_ctrl (
   input  logic                 clock,
   input  logic                 reset,
   input  logic                 req_valid,
   output logic                 req_stall,
   input  ctlb_pkg::status_type status,
   output ctlb_pkg::cmd_type    cmd
);

   typedef enum logic [2:0] {
      S_CLEAR,
      S_IDLE,
      S_READ,
      S_DRAIN,
      S_EMIT
   } state_type;

   state_type state_ff;
   state_type state_in;

   always_comb begin
      state_in = state_ff;
      cmd      = '0;
      case (state_ff)
         S_CLEAR: begin
            cmd.clear_en = 1'b1;
            if (status.clear_last) begin
               state_in = S_IDLE;
            end
         end
         S_IDLE: begin
            if (req_valid) begin
               cmd.take = 1'b1;
               if (status.take_has_result) begin
                  state_in = S_READ;
               end
            end
         end
         S_READ: begin
            cmd.read_en = 1'b1;
            if (status.read_last) begin
               state_in = S_DRAIN;
            end
         end
         S_DRAIN: begin
            // last column still on its way out of the RAMs
            state_in = S_EMIT;
         end
         S_EMIT: begin
            if (status.out_free) begin
               cmd.load_out = 1'b1;
               state_in     = status.at_end ? S_IDLE : S_READ;
            end
         end
         default: begin
            state_in = S_CLEAR;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= S_CLEAR;
      end else begin
         state_ff <= state_in;
      end
   end

   assign req_stall = (state_ff != S_IDLE);

endmodule

// File: src/ctlb_dp.sv
// ----------------------------------------------------------------------------
// ctlb_dp
// Datapath: line store, column tracking, window registers, census compare
// and output register.
// ----------------------------------------------------------------------------
module ctlb_dp (
   input  logic                                  clock,
   input  logic                                  reset,
   input  ctlb_pkg::cmd_type                     cmd,
   output ctlb_pkg::status_type                  status,
   input  logic [ctlb_pkg::PIX_BITS-1:0]         req_pixel,
   output logic                                  rsp_valid,
   input  logic                                  rsp_stall,
   output logic [ctlb_pkg::WORD_BITS-1:0]        rsp_census_word,
   output logic [ctlb_pkg::COL_OUT_BITS-1:0]     rsp_column,
   output logic                                  rsp_last,
   input  logic                                  csr_valid,
   output logic                                  csr_ready,
   input  logic [ctlb_pkg::CFG_BITS-1:0]         csr_line_width
);

   localparam int CB = ctlb_pkg::COL_BITS;

   // configuration and line position
   logic [ctlb_pkg::CFG_BITS-1:0] line_width_ff;
   ctlb_pkg::col_type             col_count_ff;
   ctlb_pkg::slot_type            newest_ff;
   ctlb_pkg::col_type             clr_addr_ff;

   // per-item working registers
   ctlb_pkg::col_type             cur_x_ff;
   ctlb_pkg::slot_type            cur_slot_ff;
   ctlb_pkg::col_type             c_ff;
   ctlb_pkg::col_type             end_ff;
   logic [ctlb_pkg::TAP_BITS-1:0] d_ff;
   logic                          rd_pend_ff;

   ctlb_pkg::pixel_type           win_ff [ctlb_pkg::WIN_H][ctlb_pkg::WIN_W];

   logic                              rsp_valid_ff;
   logic [ctlb_pkg::WORD_BITS-1:0]    rsp_word_ff;
   logic [ctlb_pkg::COL_OUT_BITS-1:0] rsp_column_ff;
   logic                              rsp_last_ff;

   ctlb_pkg::col_type   width_m1;
   ctlb_pkg::col_type   x;
   logic                is_last;
   ctlb_pkg::col_type   start_col;
   ctlb_pkg::col_type   end_col;
   logic [CB:0]         nc;
   ctlb_pkg::col_type   rd_addr;
   ctlb_pkg::pixel_type ram_rdata [ctlb_pkg::WIN_H];
   logic [ctlb_pkg::WORD_BITS-1:0] census;

   assign csr_ready = 1'b1;
   assign x         = col_count_ff;

   // last column of a line; zero width acts as one, oversize as the maximum
   always_comb begin
      if (line_width_ff == '0) begin
         width_m1 = '0;
      end else if (line_width_ff > ctlb_pkg::CFG_BITS'(ctlb_pkg::MAX_WIDTH)) begin
         width_m1 = CB'(ctlb_pkg::MAX_WIDTH - 1);
      end else begin
         width_m1 = CB'(line_width_ff - ctlb_pkg::CFG_BITS'(1));
      end
   end

   assign is_last = (x >= width_m1);

   always_comb begin
      if (x >= CB'(ctlb_pkg::HALF_W)) begin
         start_col = x - CB'(ctlb_pkg::HALF_W);
      end else begin
         start_col = '0;
      end
      end_col = is_last ? x : start_col;
   end

   // neighbour column, clamped to the borders of the current line
   always_comb begin
      nc = {1'b0, c_ff} + (CB+1)'(d_ff);
      if (nc < (CB+1)'(ctlb_pkg::HALF_W)) begin
         nc = '0;
      end else begin
         nc = nc - (CB+1)'(ctlb_pkg::HALF_W);
      end
      if (nc > {1'b0, cur_x_ff}) begin
         nc = {1'b0, cur_x_ff};
      end
      rd_addr = nc[CB-1:0];
   end

   // one RAM per line slot, all read at the same column
   for (genvar s = 0; s < ctlb_pkg::WIN_H; s++) begin : g_slot
      logic                wr_en;
      ctlb_pkg::col_type   wr_addr;
      ctlb_pkg::pixel_type wr_data;

      assign wr_en   = cmd.clear_en ||
                       (cmd.take && (newest_ff == ctlb_pkg::SLOT_BITS'(s)));
      assign wr_addr = cmd.clear_en ? clr_addr_ff : x;
      assign wr_data = cmd.clear_en ? '0 : req_pixel;

      ctlb_ram #(
         .WIDTH (ctlb_pkg::PIX_BITS),
         .DEPTH (ctlb_pkg::MAX_WIDTH)
      ) u_ram (
         .clock   (clock),
         .wr_en   (wr_en),
         .wr_addr (wr_addr),
         .wr_data (wr_data),
         .rd_en   (cmd.read_en),
         .rd_addr (rd_addr),
         .rd_data (ram_rdata[s])
      );
   end

   // census compare over the full window, centre skipped
   always_comb begin
      int                  k;
      ctlb_pkg::pixel_type centre;
      census = '0;
      k      = 0;
      centre = win_ff[ctlb_pkg::HALF_H][ctlb_pkg::HALF_W];
      for (int r = 0; r < ctlb_pkg::WIN_H; r++) begin
         for (int d = 0; d < ctlb_pkg::WIN_W; d++) begin
            if (!(r == ctlb_pkg::HALF_H && d == ctlb_pkg::HALF_W)) begin
               if (k < ctlb_pkg::WORD_BITS) begin
                  census[k[ctlb_pkg::WORD_IDX-1:0]] = (win_ff[r][d] >= centre);
               end
               k = k + 1;
            end
         end
      end
   end

   assign status.clear_last      = (clr_addr_ff == CB'(ctlb_pkg::MAX_WIDTH - 1));
   assign status.take_has_result = is_last || (x >= CB'(ctlb_pkg::HALF_W));
   assign status.read_last       = (d_ff == ctlb_pkg::TAP_BITS'(ctlb_pkg::WIN_W - 1));
   assign status.out_free        = !rsp_valid_ff || !rsp_stall;
   assign status.at_end          = (c_ff == end_ff);

   // control state
   always_ff @(posedge clock) begin
      if (reset) begin
         line_width_ff <= ctlb_pkg::CFG_BITS'(ctlb_pkg::RESET_WIDTH);
         col_count_ff  <= '0;
         newest_ff     <= '0;
         clr_addr_ff   <= '0;
         d_ff          <= '0;
         rd_pend_ff    <= 1'b0;
         rsp_valid_ff  <= 1'b0;
      end else begin
         if (csr_valid) begin
            line_width_ff <= csr_line_width;
         end
         if (cmd.clear_en) begin
            clr_addr_ff <= clr_addr_ff + CB'(1);
         end
         if (cmd.take) begin
            if (is_last) begin
               col_count_ff <= '0;
               newest_ff    <= (newest_ff == ctlb_pkg::SLOT_BITS'(ctlb_pkg::WIN_H - 1)) ?
                               '0 : newest_ff + ctlb_pkg::SLOT_BITS'(1);
            end else begin
               col_count_ff <= x + CB'(1);
            end
         end
         if (cmd.take || cmd.load_out) begin
            d_ff <= '0;
         end else if (cmd.read_en) begin
            d_ff <= d_ff + ctlb_pkg::TAP_BITS'(1);
         end
         rd_pend_ff <= cmd.read_en;
         if (cmd.load_out) begin
            rsp_valid_ff <= 1'b1;
         end else if (!rsp_stall) begin
            rsp_valid_ff <= 1'b0;
         end
      end
   end

   // payload
   always_ff @(posedge clock) begin
      if (cmd.take) begin
         cur_x_ff    <= x;
         cur_slot_ff <= newest_ff;
         c_ff        <= start_col;
         end_ff      <= end_col;
      end else if (cmd.load_out) begin
         c_ff <= c_ff + CB'(1);
      end
      if (rd_pend_ff) begin
         for (int r = 0; r < ctlb_pkg::WIN_H; r++) begin
            for (int d = 0; d < ctlb_pkg::WIN_W - 1; d++) begin
               win_ff[r][d] <= win_ff[r][d+1];
            end
            win_ff[r][ctlb_pkg::WIN_W-1] <=
               ram_rdata[ctlb_pkg::slot_of_row(cur_slot_ff, ctlb_pkg::SLOT_BITS'(r))];
         end
      end
      if (cmd.load_out) begin
         rsp_word_ff   <= census;
         rsp_column_ff <= ctlb_pkg::COL_OUT_BITS'(c_ff);
         rsp_last_ff   <= (c_ff == end_ff);
      end
   end

   assign rsp_valid       = rsp_valid_ff;
   assign rsp_census_word = rsp_word_ff;
   assign rsp_column      = rsp_column_ff;
   assign rsp_last        = rsp_last_ff;

endmodule

// File: src/census_transform_line_buffer_core.sv
// ----------------------------------------------------------------------------
// census_transform_line_buffer_core
// 7x7 census transform over a raster stream with a seven-line store.
// ----------------------------------------------------------------------------
// Sequence: intake of the pixel that causes a word, seven column fetches,
//   one drain state, then compare and load once the output register is free.
// Throughput: no pixel is taken until every word of the last one is loaded;
//   the single read port of each line slot RAM fetches one column a cycle.
// Reset: synchronous; a clearing pass zeroes every column of the line store
//   with req_stall high, while csr writes are still taken.
module census_transform_line_buffer_core (
   input  logic                                  clock,
   input  logic                                  reset,
   // pixel input beats
   input  logic                                  req_valid,
   output logic                                  req_stall,
   input  logic [ctlb_pkg::PIX_BITS-1:0]         req_pixel,
   // census word beats
   output logic                                  rsp_valid,
   input  logic                                  rsp_stall,
   output logic [ctlb_pkg::WORD_BITS-1:0]        rsp_census_word,
   output logic [ctlb_pkg::COL_OUT_BITS-1:0]     rsp_column,
   output logic                                  rsp_last,
   // line width register
   input  logic                                  csr_valid,
   output logic                                  csr_ready,
   input  logic [ctlb_pkg::CFG_BITS-1:0]         csr_line_width
);

   // The controller only sequences; all storage and arithmetic sit in the
   // datapath. They talk through one command and one status bundle.
   ctlb_pkg::cmd_type    cmd;
   ctlb_pkg::status_type status;

   ctlb_ctrl u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_stall (req_stall),
      .status    (status),
      .cmd       (cmd)
   );

   // Each pixel beat is written into the newest line slot, then every word
   // it causes is built by fetching the seven window columns (clamped at
   // the borders) into a register window, comparing against the centre and
   // loading the output register. The output register lets the next pixel
   // beat in while the final word still waits downstream.
   ctlb_dp u_dp (
      .clock           (clock),
      .reset           (reset),
      .cmd             (cmd),
      .status          (status),
      .req_pixel       (req_pixel),
      .rsp_valid       (rsp_valid),
      .rsp_stall       (rsp_stall),
      .rsp_census_word (rsp_census_word),
      .rsp_column      (rsp_column),
      .rsp_last        (rsp_last),
      .csr_valid       (csr_valid),
      .csr_ready       (csr_ready),
      .csr_line_width  (csr_line_width)
   );

   // A pixel that causes words must hold off the next beat
   a_stall_after_result : assert property (@(posedge clock) disable iff (reset)
      (cmd.take && status.take_has_result) |=> req_stall)
      else $error("input not stalled while words are pending");

   // Never overwrite a word that is still waiting downstream
   a_load_when_free : assert property (@(posedge clock) disable iff (reset)
      cmd.load_out |-> (!rsp_valid || !rsp_stall))
      else $error("output register overwritten while stalled");

   // No word may appear while the line store is being cleared
   a_quiet_clear : assert property (@(posedge clock) disable iff (reset)
      cmd.clear_en |-> (!rsp_valid && req_stall))
      else $error("activity during clearing pass");

endmodule
